@@ rtl/rtpjpeg_pkg.sv @@
// shared types and constants of the rtp/jpeg packetizer
package rtpjpeg_pkg;

    // width of the fragment offset carried in the payload header
    localparam int OFFSET_BITS = 24;

    // configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PAYLOAD_TYPE  = 3'd0,
        CFG_JPEG_QUALITY  = 3'd1,
        CFG_SOURCE_ID     = 3'd2,
        CFG_WIDTH_BLOCKS  = 3'd3,
        CFG_HEIGHT_BLOCKS = 3'd4,
        CFG_MAX_PAYLOAD   = 3'd5,
        CFG_TS_STEP       = 3'd6
    } t_cfg_addr;

    // register reset values
    localparam logic [6:0]  RST_PAYLOAD_TYPE  = 7'd26;
    localparam logic [7:0]  RST_JPEG_QUALITY  = 8'd75;
    localparam logic [31:0] RST_SOURCE_ID     = 32'd1234;
    localparam logic [7:0]  RST_WIDTH_BLOCKS  = 8'd80;
    localparam logic [7:0]  RST_HEIGHT_BLOCKS = 8'd60;
    localparam logic [10:0] RST_MAX_PAYLOAD   = 11'd1380;
    localparam logic [31:0] RST_TS_STEP       = 32'd6000;

    // fixed header bytes
    localparam logic [7:0] RTP_FIRST_BYTE = 8'h80;
    localparam logic [7:0] MARKER_BIT     = 8'h80;

    // 20 header bytes then the data byte
    localparam int HDR_BYTES = 20;
    localparam int IDX_W     = 5;
    localparam logic [IDX_W-1:0] DATA_IDX = IDX_W'(HDR_BYTES);

    // input transaction payload
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        frame_start;
        logic [23:0] frame_bytes;
    } t_in_item;

    // output transaction payload
    typedef struct packed {
        logic [7:0] packet_byte;
        logic       packet_end;
        logic       run_last;
    } t_out_item;

endpackage

@@ rtl/rtp_jpeg_packetizer.sv @@
// rtp/jpeg packetizer top level: frame tracking, header build and byte serializer
//
// Takes one JPEG byte per input transaction and emits the RTP packet stream one
// byte per output transaction. Bytes that continue a packet, or that are
// dropped (no frame open, or an empty frame), stream at one per clock while
// the output is not stalled. A byte that opens a packet yields 21 output bytes:
// the 20 header bytes are walked out by a 5-bit byte counter in the output
// register stage, so that byte holds the output stage until its data byte, the
// last of the 21, is sent. An input register in front of the header logic takes
// the next byte while the current result is still being sent. Configuration
// writes land at once and must be issued only while no transaction is in flight.
module rtp_jpeg_packetizer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [rtpjpeg_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [rtpjpeg_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  rtpjpeg_pkg::t_in_item               i_in_item,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output rtpjpeg_pkg::t_out_item              o_out_item
);

    localparam logic [23:0] OFF_MASK =
        24'((64'd1 << rtpjpeg_pkg::OFFSET_BITS) - 64'd1);

    // configuration registers
    logic [6:0]  r_payload_type;
    logic [7:0]  r_jpeg_quality;
    logic [31:0] r_source_id;
    logic [7:0]  r_width_blocks;
    logic [7:0]  r_height_blocks;
    logic [10:0] r_max_payload;
    logic [31:0] r_ts_step;

    // frame state
    logic [15:0] r_seq;
    logic [31:0] r_ts;
    logic [23:0] r_pos;
    logic [23:0] r_len;
    logic [10:0] r_chunk_left;

    // input register
    logic                  r_in_valid;
    rtpjpeg_pkg::t_in_item r_in;

    // result register and serializer
    logic                                r_res_valid;
    logic [rtpjpeg_pkg::IDX_W-1:0]       r_idx;
    logic [7:0]                          r_res_byte;
    logic                                r_res_end;
    logic                                r_res_marker;
    logic [15:0]                         r_res_seq;
    logic [31:0]                         r_res_ts;
    logic [23:0]                         r_res_off;

    // processing signals
    logic        res_free;
    logic        consume;
    logic [23:0] cur_len;
    logic [23:0] cur_pos;
    logic [10:0] cur_chunk_left;
    logic        active;
    logic        need_hdr;
    logic [10:0] maxp;
    logic [23:0] remain;
    logic        fits;
    logic [10:0] chunk;
    logic [10:0] n_chunk_left;
    logic [23:0] n_pos;
    logic        frame_done;
    logic        last_byte;

    // handshakes
    assign last_byte   = (r_idx == rtpjpeg_pkg::DATA_IDX);
    assign res_free    = !r_res_valid || (i_out_ready && last_byte);
    assign consume     = r_in_valid && res_free;
    assign o_in_ready  = !r_in_valid || consume;
    assign o_out_valid = r_res_valid;

    // frame bookkeeping for the item in the input register
    always_comb begin
        cur_len        = r_in.frame_start ? r_in.frame_bytes : r_len;
        cur_pos        = r_in.frame_start ? 24'd0 : r_pos;
        cur_chunk_left = r_in.frame_start ? 11'd0 : r_chunk_left;
        active         = (cur_pos < cur_len);
        need_hdr       = (cur_chunk_left == 11'd0);
        maxp           = (r_max_payload == 11'd0) ? 11'd1 : r_max_payload;
        remain         = cur_len - cur_pos;
        fits           = (remain <= {13'd0, maxp});
        chunk          = fits ? remain[10:0] : maxp;
        n_chunk_left   = (need_hdr ? chunk : cur_chunk_left) - 11'd1;
        n_pos          = cur_pos + 24'd1;
        frame_done     = (n_pos >= cur_len);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_type  <= rtpjpeg_pkg::RST_PAYLOAD_TYPE;
            r_jpeg_quality  <= rtpjpeg_pkg::RST_JPEG_QUALITY;
            r_source_id     <= rtpjpeg_pkg::RST_SOURCE_ID;
            r_width_blocks  <= rtpjpeg_pkg::RST_WIDTH_BLOCKS;
            r_height_blocks <= rtpjpeg_pkg::RST_HEIGHT_BLOCKS;
            r_max_payload   <= rtpjpeg_pkg::RST_MAX_PAYLOAD;
            r_ts_step       <= rtpjpeg_pkg::RST_TS_STEP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                rtpjpeg_pkg::CFG_PAYLOAD_TYPE:  r_payload_type  <= i_cfg_wdata[6:0];
                rtpjpeg_pkg::CFG_JPEG_QUALITY:  r_jpeg_quality  <= i_cfg_wdata[7:0];
                rtpjpeg_pkg::CFG_SOURCE_ID:     r_source_id     <= i_cfg_wdata;
                rtpjpeg_pkg::CFG_WIDTH_BLOCKS:  r_width_blocks  <= i_cfg_wdata[7:0];
                rtpjpeg_pkg::CFG_HEIGHT_BLOCKS: r_height_blocks <= i_cfg_wdata[7:0];
                rtpjpeg_pkg::CFG_MAX_PAYLOAD:   r_max_payload   <= i_cfg_wdata[10:0];
                rtpjpeg_pkg::CFG_TS_STEP:       r_ts_step       <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // frame state update when the input item is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq        <= 16'd0;
            r_ts         <= 32'd0;
            r_pos        <= 24'd0;
            r_len        <= 24'd0;
            r_chunk_left <= 11'd0;
        end else if (consume) begin
            r_len        <= cur_len;
            r_pos        <= cur_pos;
            r_chunk_left <= cur_chunk_left;
            if (active) begin
                r_pos        <= n_pos;
                r_chunk_left <= n_chunk_left;
                if (need_hdr) begin
                    r_seq <= r_seq + 16'd1;
                end
                if (frame_done) begin
                    r_ts <= r_ts + r_ts_step;
                end
            end
        end
    end

    // result register and byte counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (last_byte) begin
                    r_res_valid <= 1'b0;
                end else begin
                    r_idx <= r_idx + rtpjpeg_pkg::IDX_W'(1);
                end
            end
            if (consume && active) begin
                r_res_valid <= 1'b1;
                r_idx       <= need_hdr ? '0 : rtpjpeg_pkg::DATA_IDX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && active) begin
            r_res_byte   <= r_in.data_byte;
            r_res_end    <= (n_chunk_left == 11'd0);
            r_res_marker <= fits;
            r_res_seq    <= r_seq;
            r_res_ts     <= r_ts;
            r_res_off    <= cur_pos & OFF_MASK;
        end
    end

    // output byte select
    always_comb begin
        o_out_item.packet_end = last_byte && r_res_end;
        o_out_item.run_last   = last_byte;
        case (r_idx)
            5'd0:    o_out_item.packet_byte = rtpjpeg_pkg::RTP_FIRST_BYTE;
            5'd1:    o_out_item.packet_byte = (r_res_marker ? rtpjpeg_pkg::MARKER_BIT : 8'h00)
                                              | {1'b0, r_payload_type};
            5'd2:    o_out_item.packet_byte = r_res_seq[15:8];
            5'd3:    o_out_item.packet_byte = r_res_seq[7:0];
            5'd4:    o_out_item.packet_byte = r_res_ts[31:24];
            5'd5:    o_out_item.packet_byte = r_res_ts[23:16];
            5'd6:    o_out_item.packet_byte = r_res_ts[15:8];
            5'd7:    o_out_item.packet_byte = r_res_ts[7:0];
            5'd8:    o_out_item.packet_byte = r_source_id[31:24];
            5'd9:    o_out_item.packet_byte = r_source_id[23:16];
            5'd10:   o_out_item.packet_byte = r_source_id[15:8];
            5'd11:   o_out_item.packet_byte = r_source_id[7:0];
            5'd12:   o_out_item.packet_byte = 8'h00;
            5'd13:   o_out_item.packet_byte = r_res_off[23:16];
            5'd14:   o_out_item.packet_byte = r_res_off[15:8];
            5'd15:   o_out_item.packet_byte = r_res_off[7:0];
            5'd16:   o_out_item.packet_byte = 8'h00;
            5'd17:   o_out_item.packet_byte = r_jpeg_quality;
            5'd18:   o_out_item.packet_byte = r_width_blocks;
            5'd19:   o_out_item.packet_byte = r_height_blocks;
            default: o_out_item.packet_byte = r_res_byte;
        endcase
    end

endmodule

@@ rtl/rtpjpeg_checker.sv @@
// port-level checker for the rtp/jpeg packetizer and its bind
module rtpjpeg_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_in_ready,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input rtpjpeg_pkg::t_out_item o_out_item
);

    // a stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output transaction changed while stalled");

    // a packet only ends on the last byte of a run
    a_end_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.packet_end |-> o_out_item.run_last)
        else $error("packet end outside last byte of a run");

    // a run keeps going until its last byte is sent
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_item.run_last |=> o_out_valid)
        else $error("run broken before its last byte");

    // reset empties both sides
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not empty after reset");

endmodule

bind rtp_jpeg_packetizer rtpjpeg_checker u_rtpjpeg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
